// File: rtl/lbcd_pkg.sv
// Package with shared types and constants of the block cache directory.
`timescale 1ns / 1ps
package lbcd_pkg;
  localparam int SLOTS_DEF = 128;
  localparam int INITIAL_SLOTS_DEF = 0;
  localparam int TAG_W = 32;
  localparam int PIN_W = 8;
  localparam int STAMP_W = 64;
  localparam int SLOT_W = 7;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_TOUCH   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN_READ,
    CMD_SCAN_EVAL,
    CMD_SEL_READ,
    CMD_COMMIT
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic op_acquire;
  } dp_status_t;
endpackage

// File: rtl/lbcd_if.sv
// Valid/ready channel interfaces for items in and results out.
`timescale 1ns / 1ps
interface lbcd_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [31:0] block_number;
  logic [6:0] slot;
  modport source (output valid, output action, output block_number, output slot, input ready);
  modport sink (input valid, input action, input block_number, input slot, output ready);
endinterface

interface lbcd_out_if;
  logic valid;
  logic ready;
  logic [6:0] slot_index;
  logic hit;
  logic needs_fill;
  logic [1:0] status;
  modport source (output valid, output slot_index, output hit, output needs_fill, output status,
                  input ready);
  modport sink (input valid, input slot_index, input hit, input needs_fill, input status,
                output ready);
endinterface

// File: rtl/lru_block_cache_directory_top.sv
// Top level of the block cache directory.
// Release, pin and touch pass through the check, select and commit states before the result valid rises.
// Acquire first scans the slots in use, a read and an evaluate state per slot, as the slot store has one read port.
// One item is in work at a time; the next can be taken in the cycle after the result leaves.
// Synchronous reset clears all slots via valid bits and sets the clock to one.
`timescale 1ns / 1ps
module lru_block_cache_directory_top #(
  parameter int SLOTS = lbcd_pkg::SLOTS_DEF,
  parameter int INITIAL_SLOTS = lbcd_pkg::INITIAL_SLOTS_DEF
) (
  input logic clk,
  input logic rst,
  lbcd_in_if.sink in_ch,
  lbcd_out_if.source out_ch
);
  lbcd_pkg::cmd_t cmd;
  lbcd_pkg::dp_status_t stat;

  lbcd_ctrl u_ctrl (.clk, .rst, .in_ch, .out_ch, .stat, .cmd);

  lbcd_datapath #(.SLOTS(SLOTS), .INITIAL_SLOTS(INITIAL_SLOTS)) u_dp (
    .clk, .rst, .cmd,
    .in_action(in_ch.action), .in_block(in_ch.block_number), .in_slot(in_ch.slot),
    .stat,
    .res_slot(out_ch.slot_index), .res_hit(out_ch.hit), .res_fill(out_ch.needs_fill),
    .res_status(out_ch.status)
  );
endmodule

// File: rtl/lbcd_datapath.sv
// Slot store, scan compare and update logic of the directory.
`timescale 1ns / 1ps
module lbcd_datapath #(
  parameter int SLOTS = lbcd_pkg::SLOTS_DEF,
  parameter int INITIAL_SLOTS = lbcd_pkg::INITIAL_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  lbcd_pkg::cmd_t cmd,
  input  logic [1:0] in_action,
  input  logic [31:0] in_block,
  input  logic [6:0] in_slot,
  output lbcd_pkg::dp_status_t stat,
  output logic [6:0] res_slot,
  output logic res_hit,
  output logic res_fill,
  output logic [1:0] res_status
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int INIT = (INITIAL_SLOTS > SLOTS) ? SLOTS : INITIAL_SLOTS;

  logic [lbcd_pkg::TAG_W-1:0] tag_mem [SLOTS];
  logic [lbcd_pkg::STAMP_W-1:0] stamp_mem [SLOTS];
  logic [lbcd_pkg::PIN_W-1:0] pin_mem [SLOTS];
  logic [SLOTS-1:0] valid_bits;
  logic [SLOTS-1:0] written;

  logic [CW-1:0] in_use;
  logic [lbcd_pkg::STAMP_W-1:0] clock_cnt;
  logic [1:0] act;
  logic [31:0] bn;
  logic [6:0] sl;
  logic [lbcd_pkg::STAMP_W-1:0] ts;
  logic [CW-1:0] idx;
  logic found, hit;
  logic [IW-1:0] pick;
  logic [lbcd_pkg::STAMP_W-1:0] pick_stamp;
  logic [lbcd_pkg::TAG_W-1:0] rd_tag;
  logic [lbcd_pkg::STAMP_W-1:0] rd_stamp;
  logic [lbcd_pkg::PIN_W-1:0] rd_pin;
  logic rd_ok;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] tgt;
  logic sel_ok, grow;
  logic in_range;

  assign in_range = {25'd0, sl} < 32'(SLOTS);
  assign stat.op_acquire = (act == lbcd_pkg::ACT_ACQUIRE);
  assign stat.scan_done = hit || (idx >= in_use);

  always_comb begin
    rd_addr = tgt;
    if (cmd == lbcd_pkg::CMD_SCAN_READ) rd_addr = idx[IW-1:0];
    if (cmd == lbcd_pkg::CMD_SEL_READ) begin
      rd_addr = pick;
      if (act != lbcd_pkg::ACT_ACQUIRE) rd_addr = IW'(sl);
      else if (!found) rd_addr = in_use[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
    rd_pin <= pin_mem[rd_addr];
    rd_ok <= written[rd_addr];
  end

  logic [lbcd_pkg::TAG_W-1:0] tag_v;
  logic [lbcd_pkg::STAMP_W-1:0] stamp_v;
  logic [lbcd_pkg::PIN_W-1:0] pin_v;
  assign tag_v = rd_ok ? rd_tag : '0;
  assign stamp_v = rd_ok ? rd_stamp : '0;
  assign pin_v = rd_ok ? rd_pin : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= CW'(INIT);
      clock_cnt <= 64'd1;
      written <= '0;
      valid_bits <= '0;
    end else begin
      unique case (cmd)
        lbcd_pkg::CMD_LOAD: begin
          act <= in_action;
          bn <= in_block;
          sl <= in_slot;
          idx <= '0;
          found <= 1'b0;
          hit <= 1'b0;
          pick <= '0;
          ts <= clock_cnt;
          if (in_action == lbcd_pkg::ACT_ACQUIRE) clock_cnt <= clock_cnt + 64'd1;
        end
        lbcd_pkg::CMD_SCAN_EVAL: begin
          idx <= idx + CW'(1);
          if (tag_v == bn) begin
            hit <= 1'b1;
            found <= 1'b1;
            pick <= idx[IW-1:0];
          end else if (pin_v == '0 && (!found || pick_stamp > stamp_v)) begin
            found <= 1'b1;
            pick <= idx[IW-1:0];
            pick_stamp <= stamp_v;
          end
        end
        lbcd_pkg::CMD_SEL_READ: begin
          tgt <= rd_addr;
          grow <= !found && act == lbcd_pkg::ACT_ACQUIRE;
          sel_ok <= found || (in_use < CW'(SLOTS));
        end
        lbcd_pkg::CMD_COMMIT: begin
          res_hit <= 1'b0;
          res_fill <= 1'b0;
          res_status <= lbcd_pkg::ST_OK;
          res_slot <= sl;
          if (act == lbcd_pkg::ACT_ACQUIRE) begin
            if (!sel_ok) begin
              res_slot <= '0;
              res_status <= lbcd_pkg::ST_FULL;
            end else begin
              if (grow) in_use <= in_use + CW'(1);
              res_slot <= 7'(tgt);
              res_hit <= hit;
              if (pin_v == 8'hFF) begin
                res_status <= lbcd_pkg::ST_OVERFLOW;
              end else begin
                res_fill <= (tag_v != bn) || !valid_bits[tgt];
                tag_mem[tgt] <= bn;
                pin_mem[tgt] <= pin_v + 8'd1;
                stamp_mem[tgt] <= ts;
                written[tgt] <= 1'b1;
                valid_bits[tgt] <= 1'b1;
              end
            end
          end else if (in_range) begin
            unique case (act)
              lbcd_pkg::ACT_RELEASE: begin
                if (pin_v == '0) res_status <= lbcd_pkg::ST_UNDERFLOW;
                else begin
                  pin_mem[tgt] <= pin_v - 8'd1;
                  tag_mem[tgt] <= tag_v;
                  stamp_mem[tgt] <= stamp_v;
                  written[tgt] <= 1'b1;
                end
              end
              lbcd_pkg::ACT_PIN: begin
                if (pin_v == 8'hFF) res_status <= lbcd_pkg::ST_OVERFLOW;
                else begin
                  pin_mem[tgt] <= pin_v + 8'd1;
                  tag_mem[tgt] <= tag_v;
                  stamp_mem[tgt] <= stamp_v;
                  written[tgt] <= 1'b1;
                end
              end
              default: begin
                stamp_mem[tgt] <= clock_cnt;
                tag_mem[tgt] <= tag_v;
                pin_mem[tgt] <= pin_v;
                written[tgt] <= 1'b1;
                clock_cnt <= clock_cnt + 64'd1;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/lbcd_ctrl.sv
// Sequencer that steps the datapath through one item at a time.
`timescale 1ns / 1ps
module lbcd_ctrl (
  input  logic clk,
  input  logic rst,
  lbcd_in_if.sink in_ch,
  lbcd_out_if.source out_ch,
  input  lbcd_pkg::dp_status_t stat,
  output lbcd_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_EVAL, S_SEL, S_COMMIT, S_OUT} state_t;
  state_t state;

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_IDLE:   cmd = (in_ch.valid) ? lbcd_pkg::CMD_LOAD : lbcd_pkg::CMD_NONE;
      S_CHECK:  cmd = (stat.op_acquire && !stat.scan_done) ? lbcd_pkg::CMD_SCAN_READ
                                                          : lbcd_pkg::CMD_SEL_READ;
      S_EVAL:   cmd = lbcd_pkg::CMD_SCAN_EVAL;
      S_SEL:    cmd = lbcd_pkg::CMD_NONE;
      S_COMMIT: cmd = lbcd_pkg::CMD_COMMIT;
      default:  cmd = lbcd_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) state <= S_CHECK;
        S_CHECK: state <= (stat.op_acquire && !stat.scan_done) ? S_EVAL : S_SEL;
        S_EVAL: state <= S_CHECK;
        S_SEL: state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_OUT;
          out_ch.valid <= 1'b1;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("accepted while busy");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |=> out_ch.valid) else $error("commit without result");
endmodule
